@@ design/assert_macros.svh @@
// Assertion macros used by the integer ALU top.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ design/sh4alu_pkg.sv @@
// Operation codes and shared types of the integer ALU.
// Depends on nothing.
`timescale 1ns / 1ps
package sh4alu_pkg;

	typedef enum logic [3:0] {
		MODE_ADC       = 4'd0,
		MODE_SBC       = 4'd1,
		MODE_NEGC      = 4'd2,
		MODE_ROCL      = 4'd3,
		MODE_ROCR      = 4'd4,
		MODE_SHLD      = 4'd5,
		MODE_SHAD      = 4'd6,
		MODE_MULU64    = 4'd7,
		MODE_MULS64    = 4'd8,
		MODE_ANYBYTEEQ = 4'd9
	} mode_t;

	localparam logic [31:0] BYTE3_MASK = 32'hFF00_0000;
	localparam logic [31:0] BYTE2_MASK = 32'h00FF_0000;
	localparam logic [31:0] BYTE1_MASK = 32'h0000_FF00;
	localparam logic [31:0] BYTE0_MASK = 32'h0000_00FF;
	localparam logic [4:0]  SHIFT_MASK = 5'h1F;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic        hv;
	} alu_res_t;

endpackage

@@ design/sh4alu_mul.sv @@
// Multiplier stage: 32x32 unsigned product and signed high-word correction.
// Depends on sh4alu_pkg.
`timescale 1ns / 1ps
module sh4alu_mul
	import sh4alu_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] a_s1,
	input  logic [31:0] b_s1,
	output logic [63:0] prod_s2,
	output logic [31:0] corr_s2
);

	logic [63:0] prod;
	logic [31:0] corr;

	always_comb begin
		prod = {32'd0, a_s1} * {32'd0, b_s1};
		corr = (a_s1[31] ? b_s1 : 32'd0) + (b_s1[31] ? a_s1 : 32'd0);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		corr_s2 <= corr;
	end

endmodule

@@ design/sh4alu_ops.sv @@
// Registered operations: carry arithmetic, rotates, dynamic shifts, byte test.
// Depends on sh4alu_pkg.
`timescale 1ns / 1ps
module sh4alu_ops
	import sh4alu_pkg::*;
(
	input  logic        clk,
	input  logic [3:0]  mode_s1,
	input  logic [31:0] a_s1,
	input  logic [31:0] b_s1,
	input  logic        c_s1,
	output alu_res_t    res_s2
);

	alu_res_t    res;
	logic [32:0] sum;
	logic [32:0] diff;
	logic [32:0] neg;
	logic [4:0]  left_amt;
	logic [4:0]  right_amt;
	logic [31:0] shl;
	logic [31:0] shr_log;
	logic [31:0] shr_ari;
	logic [31:0] fill;
	logic [31:0] x;
	logic        any_eq;

	always_comb begin
		sum       = {1'b0, a_s1} + {1'b0, b_s1} + {32'd0, c_s1};
		diff      = {1'b0, a_s1} - {1'b0, b_s1} - {32'd0, c_s1};
		neg       = 33'd0 - {1'b0, a_s1} - {32'd0, c_s1};
		left_amt  = b_s1[4:0] & SHIFT_MASK;
		right_amt = (~b_s1[4:0] + 5'd1) & SHIFT_MASK;
		shl       = a_s1 << left_amt;
		shr_log   = a_s1 >> right_amt;
		shr_ari   = 32'($signed(a_s1) >>> right_amt);
		fill      = {32{a_s1[31]}};
		x         = a_s1 ^ b_s1;
		any_eq    = ((x & BYTE3_MASK) == 32'd0) || ((x & BYTE2_MASK) == 32'd0) ||
		            ((x & BYTE1_MASK) == 32'd0) || ((x & BYTE0_MASK) == 32'd0);
		res       = '0;
		unique case (mode_s1)
			MODE_ADC: begin
				res.lo = sum[31:0];
				res.hi = {31'd0, sum[32]};
				res.hv = 1'b1;
			end
			MODE_SBC: begin
				res.lo = diff[31:0];
				res.hi = {31'd0, diff[32]};
				res.hv = 1'b1;
			end
			MODE_NEGC: begin
				res.lo = neg[31:0];
				res.hi = {31'd0, neg[32]};
				res.hv = 1'b1;
			end
			MODE_ROCL: begin
				res.lo = {a_s1[30:0], c_s1};
				res.hi = {31'd0, a_s1[31]};
				res.hv = 1'b1;
			end
			MODE_ROCR: begin
				res.lo = {c_s1, a_s1[31:1]};
				res.hi = {31'd0, a_s1[0]};
				res.hv = 1'b1;
			end
			MODE_SHLD: begin
				if (!b_s1[31]) begin
					res.lo = shl;
				end else if (b_s1[4:0] == 5'd0) begin
					res.lo = 32'd0;
				end else begin
					res.lo = shr_log;
				end
			end
			MODE_SHAD: begin
				if (!b_s1[31]) begin
					res.lo = shl;
				end else if (b_s1[4:0] == 5'd0) begin
					res.lo = fill;
				end else begin
					res.lo = shr_ari;
				end
			end
			MODE_ANYBYTEEQ: begin
				res.lo = {31'd0, any_eq};
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule

@@ design/sh4_integer_alu_ops_top.sv @@
// Integer ALU top: input register, execute stage, result register.
// A beat passes the input register, the execute-stage registers and the result register to the result ports.
// Throughput: one beat per cycle; busy stays low and nothing stalls.
// Reset: arst_n clears the valid bits, so no done strobe follows reset.
// Depends on sh4alu_pkg, sh4alu_mul, sh4alu_ops and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sh4_integer_alu_ops_top
	import sh4alu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  mode,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic        carry_in,
	output logic        done,
	output logic [31:0] result_low,
	output logic [31:0] result_high,
	output logic        high_valid
);

	logic        valid_s1;
	logic [3:0]  mode_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic        c_s1;
	logic        valid_s2;
	logic [3:0]  mode_s2;
	logic [63:0] prod_s2;
	logic [31:0] corr_s2;
	alu_res_t    ops_s2;
	alu_res_t    fin;
	logic        valid_s3;
	alu_res_t    res_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		a_s1    <= operand_a;
		b_s1    <= operand_b;
		c_s1    <= carry_in;
		mode_s2 <= mode_s1;
		res_s3  <= fin;
	end

	sh4alu_mul u_mul (
		.clk     (clk),
		.a_s1    (a_s1),
		.b_s1    (b_s1),
		.prod_s2 (prod_s2),
		.corr_s2 (corr_s2)
	);

	sh4alu_ops u_ops (
		.clk     (clk),
		.mode_s1 (mode_s1),
		.a_s1    (a_s1),
		.b_s1    (b_s1),
		.c_s1    (c_s1),
		.res_s2  (ops_s2)
	);

	always_comb begin
		fin = ops_s2;
		unique case (mode_s2)
			MODE_MULU64: begin
				fin.lo = prod_s2[31:0];
				fin.hi = prod_s2[63:32];
				fin.hv = 1'b1;
			end
			MODE_MULS64: begin
				fin.lo = prod_s2[31:0];
				fin.hi = prod_s2[63:32] - corr_s2;
				fin.hv = 1'b1;
			end
			default: begin
				fin = ops_s2;
			end
		endcase
	end

	assign done        = valid_s3;
	assign result_low  = res_s3.lo;
	assign result_high = res_s3.hi;
	assign high_valid  = res_s3.hv;

	`ASSERT_CLK(a_start_to_done, clk, arst_n, (start && !busy) |-> ##3 done)
	`ASSERT_CLK(a_done_from_start, clk, arst_n, done |-> $past(start, 3))
	`ASSERT_NEVER(a_high_without_valid, clk, arst_n, done && !high_valid && (result_high != 32'd0))
	`ASSERT_NEVER(a_undef_mode_nonzero, clk, arst_n, valid_s2 && (mode_s2 > MODE_ANYBYTEEQ) && (fin != '0))

endmodule

@@ tb/sv/sh4_integer_alu_ops_top_tb.sv @@
// Self-checking testbench for sh4_integer_alu_ops_top: a directed table, then random beats.
// Each accepted beat is checked against an in-bench ALU predictor, or against a typed-in result.
// Depends on sh4alu_pkg and the integer ALU design files.
`timescale 1ns / 1ps
module sh4_integer_alu_ops_top_tb
	import sh4alu_pkg::*;
();

	localparam logic [3:0] MODE_RSVD_FIRST = 4'd10;
	localparam logic [3:0] MODE_RSVD_LAST  = 4'd15;
	localparam int NUM_ROWS      = 28;
	localparam int RANDOM_BEATS  = 1650;
	localparam int MAX_REPORTS   = 10;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic        c;
		bit          typed;
		alu_res_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  mode = MODE_ADC;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        carry_in = 1'b0;
	logic        done;
	logic [31:0] result_low;
	logic [31:0] result_high;
	logic        high_valid;

	bit          row_typed = 1'b0;
	alu_res_t    row_want = '0;

	alu_res_t    pending_results[$];
	int          mismatch_count = 0;
	int          no_idle_left = 0;
	row_t        dir_rows [0:NUM_ROWS-1];

	sh4_integer_alu_ops_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.carry_in   (carry_in),
		.done       (done),
		.result_low (result_low),
		.result_high(result_high),
		.high_valid (high_valid)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic alu_res_t alu_execute(logic [3:0] op, logic [31:0] a, logic [31:0] b,
			logic c);
		alu_res_t    r;
		logic [63:0] wide;
		logic [31:0] neg_b;
		logic [31:0] x;
		logic [4:0]  n;
		r = '0;
		neg_b = ~b + 32'd1;
		n = neg_b[4:0] & SHIFT_MASK;
		x = a ^ b;
		case (op)
			MODE_ADC: begin
				wide = {32'd0, a} + {32'd0, b} + {63'd0, c};
				r.lo = wide[31:0];
				r.hi = {31'd0, wide[32]};
				r.hv = 1'b1;
			end
			MODE_SBC: begin
				wide = {32'd0, a} - {32'd0, b} - {63'd0, c};
				r.lo = wide[31:0];
				r.hi = {31'd0, wide[63]};
				r.hv = 1'b1;
			end
			MODE_NEGC: begin
				wide = 64'd0 - {32'd0, a} - {63'd0, c};
				r.lo = wide[31:0];
				r.hi = {31'd0, wide[63]};
				r.hv = 1'b1;
			end
			MODE_ROCL: begin
				r.lo = {a[30:0], c};
				r.hi = {31'd0, a[31]};
				r.hv = 1'b1;
			end
			MODE_ROCR: begin
				r.lo = {c, a[31:1]};
				r.hi = {31'd0, a[0]};
				r.hv = 1'b1;
			end
			MODE_SHLD, MODE_SHAD: begin
				if (!b[31])
					r.lo = a << (b[4:0] & SHIFT_MASK);
				else if ((b[4:0] & SHIFT_MASK) == 5'd0)
					r.lo = (op == MODE_SHAD) ? {32{a[31]}} : 32'd0;
				else if (op == MODE_SHAD)
					r.lo = $signed(a) >>> n;
				else
					r.lo = a >> n;
			end
			MODE_MULU64: begin
				wide = {32'd0, a} * {32'd0, b};
				r.lo = wide[31:0];
				r.hi = wide[63:32];
				r.hv = 1'b1;
			end
			MODE_MULS64: begin
				wide = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				r.lo = wide[31:0];
				r.hi = wide[63:32];
				r.hv = 1'b1;
			end
			MODE_ANYBYTEEQ: begin
				r.lo = {31'd0, ((x & BYTE3_MASK) == 32'd0) || ((x & BYTE2_MASK) == 32'd0) ||
					((x & BYTE1_MASK) == 32'd0) || ((x & BYTE0_MASK) == 32'd0)};
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// record each accepted beat, check each done strobe against the oldest expectation
	always @(posedge clk) begin
		alu_res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected result lo=%h hi=%h hv=%b", $realtime,
							result_low, result_high, high_valid);
				end else begin
					want = pending_results.pop_front();
					if (result_low !== want.lo || result_high !== want.hi ||
							high_valid !== want.hv) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: mismatch exp lo=%h hi=%h hv=%b got lo=%h hi=%h hv=%b",
								$realtime, want.lo, want.hi, want.hv,
								result_low, result_high, high_valid);
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(row_typed ? row_want :
					alu_execute(mode, operand_a, operand_b, carry_in));
		end
	end

	task automatic send_beat(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic c,
			bit typed, alu_res_t want);
		int gap;
		start <= 1'b1;
		mode <= op;
		operand_a <= a;
		operand_b <= b;
		carry_in <= c;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (no_idle_left > 0) begin
			gap = 0;
			no_idle_left--;
		end else if ($urandom_range(0, 99) == 0) begin
			gap = 0;
			no_idle_left = $urandom_range(20, 80);
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gap = 0;
				6, 7, 8: gap = $urandom_range(1, 3);
				default: gap = $urandom_range(4, 20);
			endcase
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'd1 << $urandom_range(0, 31);
			5: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] lane;
		dir_rows = '{
			'{MODE_ADC,       32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, '{32'h0, 32'h1, 1'b1}},
			'{MODE_ADC,       32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b1}},
			'{MODE_ADC,       32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
				'{32'h8000_0000, 32'h0, 1'b1}},
			'{MODE_ADC,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
				'{32'hFFFF_FFFF, 32'h1, 1'b1}},
			'{MODE_SBC,       32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
				'{32'hFFFF_FFFF, 32'h1, 1'b1}},
			'{MODE_SBC,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b1}},
			'{MODE_SBC,       32'h1234_5678, 32'h0ABC_DEF0, 1'b1, 1'b0, '{32'h0, 32'h0, 1'b0}},
			'{MODE_NEGC,      32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b1}},
			'{MODE_NEGC,      32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
				'{32'hFFFF_FFFF, 32'h1, 1'b1}},
			'{MODE_NEGC,      32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1,
				'{32'h8000_0000, 32'h1, 1'b1}},
			'{MODE_ROCL,      32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, '{32'h1, 32'h1, 1'b1}},
			'{MODE_ROCL,      32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
				'{32'hFFFF_FFFE, 32'h0, 1'b1}},
			'{MODE_ROCR,      32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1, '{32'h0, 32'h1, 1'b1}},
			'{MODE_ROCR,      32'hFFFF_FFFE, 32'h0000_0000, 1'b1, 1'b1,
				'{32'hFFFF_FFFF, 32'h0, 1'b1}},
			'{MODE_SHLD,      32'h0000_0001, 32'h0000_001F, 1'b0, 1'b1,
				'{32'h8000_0000, 32'h0, 1'b0}},
			'{MODE_SHLD,      32'h1234_5678, 32'h0000_0020, 1'b0, 1'b1,
				'{32'h1234_5678, 32'h0, 1'b0}},
			'{MODE_SHLD,      32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1,
				'{32'h4000_0000, 32'h0, 1'b0}},
			'{MODE_SHLD,      32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, '{32'h0, 32'h0, 1'b0}},
			'{MODE_SHAD,      32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1,
				'{32'hFFFF_FFFF, 32'h0, 1'b0}},
			'{MODE_SHAD,      32'h7FFF_FFFF, 32'hFFFF_FFE0, 1'b0, 1'b1, '{32'h0, 32'h0, 1'b0}},
			'{MODE_SHAD,      32'h8000_0000, 32'hFFFF_FFE1, 1'b0, 1'b1,
				'{32'hFFFF_FFFF, 32'h0, 1'b0}},
			'{MODE_MULU64,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
				'{32'h1, 32'hFFFF_FFFE, 1'b1}},
			'{MODE_MULS64,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'h1, 32'h0, 1'b1}},
			'{MODE_MULS64,    32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
				'{32'h0, 32'h4000_0000, 1'b1}},
			'{MODE_MULS64,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, '{32'h0, 32'h0, 1'b0}},
			'{MODE_ANYBYTEEQ, 32'h1234_5678, 32'h8765_4378, 1'b0, 1'b1, '{32'h1, 32'h0, 1'b0}},
			'{MODE_ANYBYTEEQ, 32'h0102_0304, 32'h1020_3040, 1'b1, 1'b1, '{32'h0, 32'h0, 1'b0}},
			'{MODE_RSVD_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h0, 32'h0, 1'b0}}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
				dir_rows[i].typed, dir_rows[i].want);
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if ($urandom_range(0, 19) == 0)
				op = 4'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
			else
				op = 4'($urandom_range(MODE_ADC, MODE_ANYBYTEEQ));
			a = pick_operand();
			b = pick_operand();
			// bias shift amounts toward small signed values around the wrap points
			if ((op == MODE_SHLD || op == MODE_SHAD) && $urandom_range(0, 1) == 1)
				b = $urandom_range(0, 72) - 36;
			// keep some byte lanes equal so the byte test hits both answers
			if (op == MODE_ANYBYTEEQ && $urandom_range(0, 1) == 1) begin
				lane = BYTE0_MASK << (8 * $urandom_range(0, 3));
				b = a ^ ($urandom & ~lane);
			end
			send_beat(op, a, b, 1'($urandom_range(0, 1)), 1'b0, '0);
		end
		start <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("** sh4_integer_alu_ops_top: PASSED **");
		else
			$display("** sh4_integer_alu_ops_top: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** sh4_integer_alu_ops_top: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/sh4alu_pkg.sv
design/sh4alu_mul.sv
design/sh4alu_ops.sv
design/sh4_integer_alu_ops_top.sv
tb/sv/sh4_integer_alu_ops_top_tb.sv
